/* rtl/pap_pkg.sv */
`timescale 1ns / 1ps

package pap_pkg;

  // Field widths
  localparam int SAMPLE_W   = 12;
  localparam int PRES_W     = 14;
  localparam int LIMIT_W    = 14;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 16;

  // Window of scaled values
  localparam int WINDOW_DEPTH = 8;
  localparam int RESET_ENTRY  = 331;
  localparam int SCALED_MAX   = 11079;
  localparam int SUM_W        = $clog2(SCALED_MAX * WINDOW_DEPTH + 1);
  localparam int SUM_RESET    = RESET_ENTRY * WINDOW_DEPTH;

  // Converter scaling: floor(SCALE_NUM * (sample + SAMPLE_OFFSET) / SCALE_DEN)
  localparam int SCALE_NUM     = 8000;
  localparam int SCALE_DEN     = 2993;
  localparam int SAMPLE_OFFSET = 50;
  localparam int OFFS_W        = $clog2((1 << SAMPLE_W) + SAMPLE_OFFSET);
  localparam int NUM_W         = $clog2(SCALE_NUM);
  localparam int PROD_W        = $clog2(SCALE_NUM * ((1 << SAMPLE_W) - 1 + SAMPLE_OFFSET) + 1);

  // Reciprocal for the divide by SCALE_DEN, exact for PROD_W-bit numerators
  localparam int DIV_L    = $clog2(SCALE_DEN);
  localparam int DIV_K    = PROD_W + DIV_L;
  localparam longint unsigned DIV_M =
      ((64'd1 << DIV_K) + SCALE_DEN - 1) / SCALE_DEN;
  localparam int DIV_M_W  = PROD_W + 1;
  localparam int DIV_P_W  = PROD_W + DIV_M_W;

  // Reciprocal for the divide by WINDOW_DEPTH, exact for SUM_W-bit sums
  localparam int MEAN_L   = $clog2(WINDOW_DEPTH);
  localparam int MEAN_K   = SUM_W + MEAN_L;
  localparam longint unsigned MEAN_M =
      ((64'd1 << MEAN_K) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam int MEAN_M_W = SUM_W + 1;
  localparam int MEAN_P_W = SUM_W + MEAN_M_W;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = CFG_IDX_W'(1);

  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RESET = LIMIT_W'(16383);
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RESET  = LIMIT_W'(0);

  typedef struct packed {
    logic [LIMIT_W-1:0] high;
    logic [LIMIT_W-1:0] low;
  } pap_limits_t;

  // One scaled word moving from the queue to the back end
  typedef struct packed {
    logic              valid;
    logic [PRES_W-1:0] value;
  } pap_word_t;

endpackage

/* rtl/pap_front.sv */
`timescale 1ns / 1ps

module pap_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pap_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [11:0] adc_sample
  output logic                          push_valid_o,
  output logic [pap_pkg::PRES_W-1:0]    push_value_o,
  input  logic                          push_ready_i
);
  import pap_pkg::*;

  logic                f1_v_q;
  logic [PROD_W-1:0]   f1_prod_q;
  logic                f2_v_q;
  logic [PRES_W-1:0]   f2_value_q;
  logic                f2_ready;
  logic                f1_ready;
  logic                in_word;
  logic [OFFS_W-1:0]   offs;
  logic [PROD_W-1:0]   f1_prod_d;
  logic [DIV_P_W-1:0]  div_prod;
  logic [PRES_W-1:0]   f2_value_d;

  assign f2_ready      = !f2_v_q || push_ready_i;
  assign f1_ready      = !f1_v_q || f2_ready;
  assign s_axis_tready = f1_ready;
  assign in_word       = s_axis_tvalid && f1_ready;

  // Stage 1: offset and multiply by the scale numerator
  assign offs      = OFFS_W'(s_axis_tdata[SAMPLE_W-1:0]) + OFFS_W'(SAMPLE_OFFSET);
  assign f1_prod_d = PROD_W'(offs) * PROD_W'(SCALE_NUM);

  // Stage 2: divide by the scale denominator through its reciprocal
  assign div_prod   = DIV_P_W'(f1_prod_q) * DIV_P_W'(DIV_M);
  assign f2_value_d = PRES_W'(div_prod >> DIV_K);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      if (f1_ready) begin
        f1_v_q <= s_axis_tvalid;
      end
      if (f2_ready) begin
        f2_v_q <= f1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_word) begin
      f1_prod_q <= f1_prod_d;
    end
    if (f2_ready && f1_v_q) begin
      f2_value_q <= f2_value_d;
    end
  end

  assign push_valid_o = f2_v_q;
  assign push_value_o = f2_value_q;

endmodule

/* rtl/pap_queue.sv */
`timescale 1ns / 1ps

module pap_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_valid_i,
  input  logic [pap_pkg::PRES_W-1:0] push_value_i,
  output logic                       push_ready_o,
  output pap_pkg::pap_word_t         head_o,
  input  logic                       pop_i
);
  import pap_pkg::*;

  logic [PRES_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.value = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_value_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("pop from empty queue");
`endif

endmodule

/* rtl/pap_back.sv */
`timescale 1ns / 1ps

module pap_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pap_pkg::pap_word_t            head_i,
  output logic                          pop_o,
  input  pap_pkg::pap_limits_t          limits_i,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pap_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [13:0] average_pressure
  output logic                          m_axis_tuser   // urgent
);
  import pap_pkg::*;

  logic [PRES_W-1:0]   win_q [WINDOW_DEPTH];
  logic [SUM_W-1:0]    sum_q;
  logic                s1_v_q;
  logic                s2_v_q;
  logic [PRES_W-1:0]   mean_q;
  logic                out_v_q;
  logic [PRES_W-1:0]   avg_q;
  logic                urg_q;
  logic                out_ready;
  logic                s2_ready;
  logic                s1_ready;
  logic [MEAN_P_W-1:0] mean_prod;
  logic [PRES_W-1:0]   mean_d;
  logic                urg_d;

  assign out_ready = !out_v_q || m_axis_tready;
  assign s2_ready  = !s2_v_q || out_ready;
  assign s1_ready  = !s1_v_q || s2_ready;
  assign pop_o     = head_i.valid && s1_ready;

  // Stage 1: shift the window and update the running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_q[i] <= PRES_W'(RESET_ENTRY);
      end
      sum_q <= SUM_W'(SUM_RESET);
    end else if (pop_o) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WINDOW_DEPTH-1] <= head_i.value;
      sum_q <= sum_q - SUM_W'(win_q[0]) + SUM_W'(head_i.value);
    end
  end

  // Stage 2: mean through the reciprocal of the window depth
  assign mean_prod = MEAN_P_W'(sum_q) * MEAN_P_W'(MEAN_M);
  assign mean_d    = PRES_W'(mean_prod >> MEAN_K);

  // Stage 3: range check, strict on both limits
  assign urg_d = (mean_q > limits_i.high) || (mean_q < limits_i.low);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= head_i.valid;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (out_ready) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      mean_q <= mean_d;
    end
    if (out_ready && s2_v_q) begin
      avg_q <= mean_q;
      urg_q <= urg_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = M_TDATA_W'(avg_q);
  assign m_axis_tuser  = urg_q;

`ifndef NO_ASSERTIONS
  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_W'(SCALED_MAX * WINDOW_DEPTH))
    else $error("running sum out of range");

  a_stall_holds_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s2_ready) |=> $stable(sum_q))
    else $error("running sum moved while stage 1 stalled");
`endif

endmodule

/* rtl/pressure_average_alarm.sv */
`timescale 1ns / 1ps

// Moving-average pressure filter with a range alarm. Each input word carries
// one raw 12-bit converter sample; it is scaled to hundreds of pascal, pushed
// into a window of the last WINDOW_DEPTH scaled values, and one output word
// per sample gives the truncated window mean with an urgent flag (mean strictly
// above the high limit or strictly below the low limit). One sample is taken
// every clock cycle while s_axis_tready is high; on its way to the output a
// result passes through the offset multiply register, the divide multiply of
// the scaler, the queue, the running-sum stage, the registered mean multiply
// and the range-check output register. Limits are written through the
// configuration channel (index 0 high, 1 low, other indexes ignored) and
// should only be changed while the pipeline is empty.
module pressure_average_alarm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [pap_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [11:0] adc_sample
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [pap_pkg::M_TDATA_W-1:0]  m_axis_tdata,  // [13:0] average_pressure
  output logic                           m_axis_tuser,  // urgent
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pap_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pap_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pap_pkg::*;

  pap_limits_t       limits_q;
  logic              push_valid;
  logic [PRES_W-1:0] push_value;
  logic              push_ready;
  pap_word_t         head;
  logic              pop;

  // Limit registers, low 14 bits of the written word kept
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.high <= HIGH_LIMIT_RESET;
      limits_q.low  <= LOW_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_HIGH_LIMIT) begin
        limits_q.high <= cfg_data_i[LIMIT_W-1:0];
      end else if (cfg_index_i == REG_LOW_LIMIT) begin
        limits_q.low <= cfg_data_i[LIMIT_W-1:0];
      end
    end
  end

  pap_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_valid_o  (push_valid),
    .push_value_o  (push_value),
    .push_ready_i  (push_ready)
  );

  pap_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_value_i (push_value),
    .push_ready_o (push_ready),
    .head_o       (head),
    .pop_i        (pop)
  );

  pap_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .limits_i      (limits_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import pap_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES  = 20;
  localparam int RAND_BLOCKS  = 6;
  localparam int BLOCK_ITEMS  = 88;
  localparam int REPORT_MAX   = 10;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] IDX_TOP    = '1;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  // One directed step: a sample (val[11:0]) or a register write (idx, val)
  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  val;
    logic                   pinned;
    logic [PRES_W-1:0]      avg;
    logic                   urg;
  } plan_row_t;

  // Output word as seen on the master side: padded mean and urgent flag
  typedef struct packed {
    logic [M_TDATA_W-1:0] avg;
    logic                 urgent;
  } mean_word_t;

  localparam int PLAN_LEN = 34;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // default limits: first sample against the reset window, then full windows
    '{ROW_SAMPLE, '0, 16'd0,    1'b1, 14'd306,   1'b0},
    '{ROW_SAMPLE, '0, 16'd4095, 1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd4095, 1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd4095, 1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd4095, 1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd4095, 1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd4095, 1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd4095, 1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd4095, 1'b1, 14'd11079, 1'b0},
    '{ROW_SAMPLE, '0, 16'd0,    1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd0,    1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd0,    1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd0,    1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd0,    1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd0,    1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd0,    1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd0,    1'b1, 14'd133,   1'b0},
    // upper data bits dropped: high limit becomes 133
    '{ROW_CFG, REG_HIGH_LIMIT, 16'hC085, 1'b0, 14'd0, 1'b0},
    '{ROW_CFG, REG_LOW_LIMIT,  16'd133,  1'b0, 14'd0, 1'b0},
    // mean equal to both limits is normal
    '{ROW_SAMPLE, '0, 16'd0,    1'b1, 14'd133,   1'b0},
    '{ROW_CFG, REG_HIGH_LIMIT, 16'd132,  1'b0, 14'd0, 1'b0},
    '{ROW_SAMPLE, '0, 16'd0,    1'b1, 14'd133,   1'b1},
    // write to an unused index leaves limits alone
    '{ROW_CFG, IDX_UNUSED,     16'h3FFF, 1'b0, 14'd0, 1'b0},
    '{ROW_SAMPLE, '0, 16'd0,    1'b1, 14'd133,   1'b1},
    // crossed limits
    '{ROW_CFG, REG_HIGH_LIMIT, 16'd100,  1'b0, 14'd0, 1'b0},
    '{ROW_CFG, REG_LOW_LIMIT,  16'd200,  1'b0, 14'd0, 1'b0},
    '{ROW_SAMPLE, '0, 16'd0,    1'b1, 14'd133,   1'b1},
    // high limit at its top, mean just below the low limit
    '{ROW_CFG, REG_HIGH_LIMIT, 16'hFFFF, 1'b0, 14'd0, 1'b0},
    '{ROW_CFG, REG_LOW_LIMIT,  16'd134,  1'b0, 14'd0, 1'b0},
    '{ROW_SAMPLE, '0, 16'd0,    1'b1, 14'd133,   1'b1},
    '{ROW_CFG, REG_LOW_LIMIT,  16'd0,    1'b0, 14'd0, 1'b0},
    '{ROW_CFG, IDX_TOP,        16'h1234, 1'b0, 14'd0, 1'b0},
    '{ROW_SAMPLE, '0, 16'd4095, 1'b0, 14'd0,     1'b0},
    '{ROW_SAMPLE, '0, 16'd2048, 1'b0, 14'd0,     1'b0}
  };

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;  // [11:0] adc_sample
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;        // [13:0] average_pressure
  logic                   m_axis_tuser;        // urgent
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // Typed expectation travelling with the sample word
  logic                   pin_on  = 1'b0;
  logic [PRES_W-1:0]      pin_avg = '0;
  logic                   pin_urg = 1'b0;

  // Shadow of the filter state
  logic [PRES_W-1:0]      win_vals [WINDOW_DEPTH];
  logic [SUM_W-1:0]       win_sum;
  logic [LIMIT_W-1:0]     lim_high;
  logic [LIMIT_W-1:0]     lim_low;

  mean_word_t             mean_q [$];
  int                     fail_count  = 0;
  int                     cycle_cnt   = 0;
  int                     tx_idle_pct = 33;
  int                     rx_idle_pct = 87;
  int                     level       = 0;

  pressure_average_alarm uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Scale one sample, slide the window, and form the mean and alarm
  function automatic mean_word_t advance_window(input logic [SAMPLE_W-1:0] smp);
    int         fresh;
    int         total;
    int         mean;
    mean_word_t w;
    fresh = ((int'(smp) + SAMPLE_OFFSET) * SCALE_NUM) / SCALE_DEN;
    total = int'(win_sum) - int'(win_vals[0]) + fresh;
    for (int i = 0; i < WINDOW_DEPTH - 1; i++) win_vals[i] = win_vals[i + 1];
    win_vals[WINDOW_DEPTH - 1] = PRES_W'(fresh);
    win_sum = SUM_W'(total);
    mean = total / WINDOW_DEPTH;
    w.avg = M_TDATA_W'(mean);
    w.urgent = (mean > int'(lim_high)) || (mean < int'(lim_low));
    return w;
  endfunction

  // Mostly a wandering level, with full-range and extreme values mixed in
  function automatic logic [SAMPLE_W-1:0] next_sample();
    int n;
    case ($urandom_range(9))
      0: n = 0;
      1: n = SAMPLE_MAX;
      2, 3: n = $urandom_range(SAMPLE_MAX);
      default: begin
        level = level + int'($urandom_range(400)) - 200;
        if (level < 0) level = 0;
        if (level > SAMPLE_MAX) level = SAMPLE_MAX;
        n = level;
      end
    endcase
    return SAMPLE_W'(n);
  endfunction

  task automatic flag_mismatch(input string what, input mean_word_t want,
                               input mean_word_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("%0t: %s: expected avg %0d urgent %0d, got avg %0d urgent %0d",
               $realtime, what, want.avg, want.urgent, got.avg, got.urgent);
  endtask

  // Input side: every accepted word advances the shadow window
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin : take_sample
      mean_word_t w;
      w = advance_window(s_axis_tdata[SAMPLE_W-1:0]);
      if (pin_on) w = '{M_TDATA_W'(pin_avg), pin_urg};
      mean_q.push_back(w);
    end
  end

  // Output side: compare against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin : check_mean
      mean_word_t got;
      mean_word_t want;
      got = '{m_axis_tdata, m_axis_tuser};
      if (mean_q.size() == 0) begin
        flag_mismatch("unexpected word", '0, got);
      end else begin
        want = mean_q.pop_front();
        if (got != want) flag_mismatch("mean mismatch", want, got);
      end
    end
  end

  // Receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic pinned,
                             input logic [PRES_W-1:0] avg, input logic urg);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(smp);
    pin_on        <= pinned;
    pin_avg       <= avg;
    pin_urg       <= urg;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off the sender until every pending mean has come out; the clock is
  // awaited first so the word accepted at the current edge is already queued
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (mean_q.size() != 0) @(posedge clk_i);
  endtask

  // Leaves valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_HIGH_LIMIT) lim_high = val[LIMIT_W-1:0];
    else if (idx == REG_LOW_LIMIT) lim_low = val[LIMIT_W-1:0];
  endtask

  task automatic shuffle_limits();
    logic [LIMIT_W-1:0] hi;
    logic [LIMIT_W-1:0] lo;
    case ($urandom_range(4))
      0: begin hi = '1; lo = '0; end
      1: begin hi = '0; lo = '1; end
      2: begin hi = LIMIT_W'($urandom); lo = LIMIT_W'($urandom); end
      default: begin
        hi = LIMIT_W'($urandom_range(2000, SCALED_MAX));
        lo = LIMIT_W'($urandom_range(133, hi));
      end
    endcase
    write_reg(REG_HIGH_LIMIT, {2'($urandom), hi});
    write_reg(REG_LOW_LIMIT, {2'($urandom), lo});
    if ($urandom_range(2) == 0) write_reg(CFG_IDX_W'($urandom), CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    for (int i = 0; i < WINDOW_DEPTH; i++) win_vals[i] = PRES_W'(RESET_ENTRY);
    win_sum  = SUM_W'(SUM_RESET);
    lim_high = HIGH_LIMIT_RESET;
    lim_low  = LOW_LIMIT_RESET;

    wait (rst_ni);
    @(posedge clk_i);

    // Directed table
    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CFG) begin
        drain();
        write_reg(PLAN[i].idx, PLAN[i].val);
      end else begin
        cfg_valid_i <= 1'b0;
        send_sample(PLAN[i].val[SAMPLE_W-1:0], PLAN[i].pinned, PLAN[i].avg, PLAN[i].urg);
      end
    end

    // Random blocks, fresh limits each time; idling pattern changes every two
    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      drain();
      shuffle_limits();
      if (blk == 2) begin
        tx_idle_pct = 87;
        rx_idle_pct = 33;
      end else if (blk == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      level = $urandom_range(SAMPLE_MAX);
      for (int n = 0; n < BLOCK_ITEMS; n++) send_sample(next_sample(), 1'b0, '0, 1'b0);
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && mean_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/pap_pkg.sv
rtl/pap_front.sv
rtl/pap_queue.sv
rtl/pap_back.sv
rtl/pressure_average_alarm.sv
tb/tb.sv
